/* design/fpm_pkg.sv */
// shared types, constants and helper functions of the polynomial multiplier
package fpm_pkg;

    localparam int MAX_TERMS = 32;
    localparam int ADDR_W    = 5;
    localparam int COUNT_W   = 6;
    localparam int COEF_W    = 12;
    localparam int PROD_W    = 24;
    localparam int RESULT_W  = 29;

    typedef struct packed {
        logic signed [COEF_W-1:0] a_coef;
        logic signed [COEF_W-1:0] b_coef;
    } fpm_in_t;

    typedef struct packed {
        logic signed [RESULT_W-1:0] product_coef;
        logic                       last_coef;
    } fpm_out_t;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_MAC,
        ST_DRAIN,
        ST_EMIT
    } fpm_state_t;

    // controller to datapath commands
    typedef struct packed {
        logic              load_we;
        logic [ADDR_W-1:0] wr_addr;
        logic              issue;
        logic              first;
        logic              in_range;
        logic [ADDR_W-1:0] rd_a;
        logic [ADDR_W-1:0] rd_b;
        logic              last;
    } fpm_cmd_t;

    // clamp the term count register into 1..MAX_TERMS
    function automatic logic [COUNT_W-1:0] eff_count(input logic [COUNT_W-1:0] tc);
        logic [COUNT_W-1:0] n;
        begin
            n = tc;
            if (tc == '0)
                n = COUNT_W'(1);
            else if (tc > COUNT_W'(MAX_TERMS))
                n = COUNT_W'(MAX_TERMS);
            return n;
        end
    endfunction

    // highest product degree emitted: 2*P - 2, P the next power of two at or above n
    function automatic logic [COUNT_W-1:0] last_degree(input logic [COUNT_W-1:0] n);
        logic [COUNT_W-1:0] d;
        begin
            case (n) inside
                [6'd0:6'd1]:   d = 6'd0;
                [6'd2:6'd2]:   d = 6'd2;
                [6'd3:6'd4]:   d = 6'd6;
                [6'd5:6'd8]:   d = 6'd14;
                [6'd9:6'd16]:  d = 6'd30;
                default:       d = 6'd62;
            endcase
            return d;
        end
    endfunction

endpackage

/* design/fft_polynomial_multiplier_unit.sv */
// top level of the polynomial multiplier: controller, datapath and checks
// Multiplies two signed 12-bit polynomials of term_count coefficients
// (1..32, 0 acts as 1, larger acts as 32). Coefficient pairs are loaded one
// request per cycle while in_stall is low, lowest degree first; after the
// last pair the block emits 2*P-1 product coefficients (P the next power of
// two at or above term_count), lowest degree first, the last one flagged by
// last_coef. Degrees above 2*term_count-2 come out as zero. Each product
// coefficient is formed by one shared 12x12 multiplier stepping through
// term_count products read from the two coefficient memories, followed by a
// pipeline drain; no input is taken while results are produced.
// term_count is written through the cfg port only while the block waits for
// pairs; a write restarts the current load.
module fft_polynomial_multiplier_unit
    import fpm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // configuration write
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [COUNT_W-1:0] cfg_data,
    // coefficient pair requests
    input  logic               in_valid,
    output logic               in_stall,
    input  fpm_in_t            in_data,
    // product coefficient requests
    output logic               out_valid,
    input  logic               out_stall,
    output fpm_out_t           out_data
);

    fpm_cmd_t cmd;

    // sequencing: load, multiply-accumulate loop, drain, emit
    fpm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    // storage and arithmetic
    fpm_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .in_data  (in_data),
        .out_data (out_data)
    );

    // inputs are never taken while a result is on offer
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input accepted while result pending");

    // after the final coefficient is taken the block returns to loading
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && out_data.last_coef) |=> (!out_valid && cfg_ready))
        else $error("result stream did not end after last coefficient");

    // config is only accepted while idle
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready |-> !out_valid)
        else $error("config ready while results pending");

endmodule

/* design/fpm_ram.sv */
// generic single-write, single-read memory with registered read data
module fpm_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* design/fpm_ctrl.sv */
// controller: load sequencing, convolution loop counters and result handshake
module fpm_ctrl
    import fpm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     cfg_valid,
    output logic     cfg_ready,
    input  logic [COUNT_W-1:0] cfg_data,
    input  logic     in_valid,
    output logic     in_stall,
    output logic     out_valid,
    input  logic     out_stall,
    output fpm_cmd_t cmd
);

    fpm_state_t         state_reg, state_next;
    logic [COUNT_W-1:0] term_count_reg, term_count_next;
    logic [ADDR_W-1:0]  load_idx_reg, load_idx_next;
    logic [ADDR_W-1:0]  i_reg, i_next;
    logic [COUNT_W-1:0] k_reg, k_next;
    logic               cnt_reg, cnt_next;

    logic [COUNT_W-1:0] n;
    logic [ADDR_W-1:0]  n_last;
    logic [COUNT_W-1:0] k_last;
    logic [COUNT_W:0]   j;
    logic               cfg_fire, in_fire;

    assign n        = eff_count(term_count_reg);
    assign n_last   = ADDR_W'(n - COUNT_W'(1));
    assign k_last   = last_degree(n);
    assign j        = {1'b0, k_reg} - {2'b00, i_reg};
    assign cfg_fire = cfg_valid && cfg_ready;
    assign in_fire  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_LOAD;
            term_count_reg <= COUNT_W'(1);
            load_idx_reg   <= '0;
            i_reg          <= '0;
            k_reg          <= '0;
            cnt_reg        <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            term_count_reg <= term_count_next;
            load_idx_reg   <= load_idx_next;
            i_reg          <= i_next;
            k_reg          <= k_next;
            cnt_reg        <= cnt_next;
        end
    end

    // next state and counters
    always_comb
    begin
        state_next      = state_reg;
        term_count_next = term_count_reg;
        load_idx_next   = load_idx_reg;
        i_next          = i_reg;
        k_next          = k_reg;
        cnt_next        = cnt_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (cfg_fire)
                begin
                    term_count_next = cfg_data;
                    load_idx_next   = '0;
                end
                else if (in_fire)
                begin
                    if (load_idx_reg == n_last)
                    begin
                        load_idx_next = '0;
                        i_next        = '0;
                        k_next        = '0;
                        state_next    = ST_MAC;
                    end
                    else
                    begin
                        load_idx_next = load_idx_reg + ADDR_W'(1);
                    end
                end
            end
            ST_MAC:
            begin
                if (i_reg == n_last)
                begin
                    cnt_next   = 1'b0;
                    state_next = ST_DRAIN;
                end
                else
                begin
                    i_next = i_reg + ADDR_W'(1);
                end
            end
            ST_DRAIN:
            begin
                if (cnt_reg)
                    state_next = ST_EMIT;
                else
                    cnt_next = 1'b1;
            end
            ST_EMIT:
            begin
                if (!out_stall)
                begin
                    if (k_reg == k_last)
                    begin
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        k_next     = k_reg + COUNT_W'(1);
                        i_next     = '0;
                        state_next = ST_MAC;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // outputs and commands
    always_comb
    begin
        cfg_ready    = (state_reg == ST_LOAD);
        in_stall     = (state_reg != ST_LOAD) || cfg_valid;
        out_valid    = (state_reg == ST_EMIT);
        cmd.load_we  = in_fire;
        cmd.wr_addr  = load_idx_reg;
        cmd.issue    = (state_reg == ST_MAC);
        cmd.first    = (i_reg == '0);
        cmd.in_range = !j[COUNT_W] && (j[COUNT_W-1:0] < n);
        cmd.rd_a     = i_reg;
        cmd.rd_b     = j[ADDR_W-1:0];
        cmd.last     = (k_reg == k_last);
    end

endmodule

/* design/fpm_datapath.sv */
// datapath: coefficient stores, multiplier and accumulator
module fpm_datapath
    import fpm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  fpm_cmd_t cmd,
    input  fpm_in_t  in_data,
    output fpm_out_t out_data
);

    logic [COEF_W-1:0]          a_rd, b_rd;
    logic                       s1_valid_reg, s1_first_reg, s1_range_reg;
    logic                       s2_valid_reg, s2_first_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [RESULT_W-1:0] acc_reg, acc_next;

    fpm_ram #(.WIDTH(COEF_W), .DEPTH(MAX_TERMS)) u_a_ram (
        .clk   (clk),
        .we    (cmd.load_we),
        .waddr (cmd.wr_addr),
        .wdata (in_data.a_coef),
        .raddr (cmd.rd_a),
        .rdata (a_rd)
    );

    fpm_ram #(.WIDTH(COEF_W), .DEPTH(MAX_TERMS)) u_b_ram (
        .clk   (clk),
        .we    (cmd.load_we),
        .waddr (cmd.wr_addr),
        .wdata (in_data.b_coef),
        .raddr (cmd.rd_b),
        .rdata (b_rd)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= cmd.issue;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    // out-of-range terms contribute zero
    always_ff @(posedge clk)
    begin
        s1_first_reg <= cmd.first;
        s1_range_reg <= cmd.in_range;
        s2_first_reg <= s1_first_reg;
        if (s1_range_reg)
            prod_reg <= $signed(a_rd) * $signed(b_rd);
        else
            prod_reg <= '0;
        acc_reg <= acc_next;
    end

    always_comb
    begin
        acc_next = acc_reg;
        if (s2_valid_reg)
        begin
            if (s2_first_reg)
                acc_next = RESULT_W'(prod_reg);
            else
                acc_next = acc_reg + RESULT_W'(prod_reg);
        end
    end

    assign out_data.product_coef = acc_reg;
    assign out_data.last_coef    = cmd.last;

endmodule
